[design/lif_pkg.sv]
`default_nettype none

package lif_pkg;

  localparam int OPCODE_W   = 2;
  localparam int CUR_IN_W   = 16;
  localparam int DT_W       = 10;
  localparam int V_W        = 16;
  localparam int ACT_W      = 17;
  localparam int KIND_W     = 2;
  localparam int DECAY_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int CUR_SUM_W   = 20;
  localparam int VW_W        = 24;
  localparam int X_W         = 24;
  localparam int MUL_A_W     = 25;
  localparam int MUL_B_W     = 31;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 32;
  localparam int KIND_NUM    = 4;
  localparam int TAU_W       = 4;
  localparam int TAU_MAX     = 15;

  localparam int SUBSTEP_COUNT_DEF = 4;

  localparam logic signed [V_W-1:0] REST_RST      = -16'sd16640;
  localparam logic signed [V_W-1:0] RESET_POT_RST = -16'sd17920;
  localparam logic signed [V_W-1:0] PEAK_RST      = 16'sd7680;
  localparam logic signed [V_W-1:0] BIAS_RST      = 16'sd0;
  localparam logic [DECAY_W-1:0]    DECAY_RST     = 16'd62259;

  localparam logic signed [CUR_SUM_W-1:0] CUR_MAX = 20'sd524287;
  localparam logic signed [CUR_SUM_W-1:0] CUR_MIN = -20'sd524288;
  localparam logic signed [V_W-1:0]       V_FLOOR = -16'sd20480;
  localparam logic [DT_W-1:0]             DT_SPLIT = 10'd384;
  localparam logic [ACT_W-1:0]            SPIKE_BOOST = 17'd26214;
  localparam logic [ACT_W-1:0]            ACT_ONE = 17'd65536;

  // sensory, inter, motor, modulatory
  localparam logic [TAU_W-1:0] KIND_TAU [KIND_NUM] = '{4'd10, 4'd8, 4'd12, 4'd15};
  localparam logic signed [V_W-1:0] KIND_THRESH [KIND_NUM] =
    '{-16'sd14080, -16'sd14080, -16'sd14336, -16'sd13824};
  localparam logic [DT_W-1:0] KIND_REFR [KIND_NUM] = '{10'd384, 10'd256, 10'd512, 10'd768};

  // floor(2^32 / tau), single-step divisors
  localparam logic [RECIP_W-1:0] RECIP_ONE [KIND_NUM] = '{
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd10),
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd8),
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd12),
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd15)
  };

  typedef enum logic [OPCODE_W-1:0] {
    OP_INJECT = 2'd0,
    OP_STEP   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KIND      = 3'd0,
    REG_REST      = 3'd1,
    REG_RESET_POT = 3'd2,
    REG_PEAK      = 3'd3,
    REG_BIAS      = 3'd4,
    REG_DECAY     = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULDT,
    ST_ABS,
    ST_RECIP,
    ST_REM,
    ST_CORR,
    ST_UPD,
    ST_FIRE,
    ST_DECAY,
    ST_DECAY_WB,
    ST_CLAMP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[design/lif_cfg_if.sv]
`default_nettype none

interface lif_cfg_if;
  import lif_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/lif_in_if.sv]
`default_nettype none

interface lif_in_if;
  import lif_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [CUR_IN_W-1:0] current_in;
  logic [DT_W-1:0]            time_step;

  modport source (output valid, opcode, current_in, time_step, input ready);
  modport sink (input valid, opcode, current_in, time_step, output ready);
endinterface

`default_nettype wire

[design/lif_out_if.sv]
`default_nettype none

interface lif_out_if;
  import lif_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  spiked;
  logic signed [V_W-1:0] membrane_voltage;
  logic [ACT_W-1:0]      activity_level;
  logic                  in_refractory;

  modport source (output valid, spiked, membrane_voltage, activity_level, in_refractory,
                  input ready);
  modport sink (input valid, spiked, membrane_voltage, activity_level, in_refractory,
                output ready);
endinterface

`default_nettype wire

[design/lif_neuron_update.sv]
// Channel   Dir  Payload                                              Handshake
// cfg_wr    in   index, data                                          valid/ready
// in_item   in   opcode, current_in, time_step                        valid/ready
// out_item  out  spiked, membrane_voltage, activity_level, in_refr.   valid/ready
//
// One item at a time. An integrating step runs n = 1 or SUBSTEP_COUNT Euler substeps on the
// one shared multiplier, used three times per Euler substep (drive*dt, reciprocal,
// remainder) and once for the activity decay, which a step that fires skips.
// A result waiting in the output register stalls only the finish of the next item.
// rst_n is synchronous: config registers and neuron state return to defaults.
`default_nettype none

module lif_neuron_update #(
  parameter int SUBSTEP_COUNT = lif_pkg::SUBSTEP_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lif_cfg_if.sink    cfg_wr,
  lif_in_if.sink     in_item,
  lif_out_if.source  out_item
);
  import lif_pkg::*;

  localparam int DEN_W = $clog2(TAU_MAX * SUBSTEP_COUNT + 1);
  localparam int SUB_W = $clog2(SUBSTEP_COUNT + 1);

  localparam logic [DEN_W-1:0] DEN_SPLIT [KIND_NUM] = '{
    DEN_W'(KIND_TAU[0] * SUBSTEP_COUNT),
    DEN_W'(KIND_TAU[1] * SUBSTEP_COUNT),
    DEN_W'(KIND_TAU[2] * SUBSTEP_COUNT),
    DEN_W'(KIND_TAU[3] * SUBSTEP_COUNT)
  };

  localparam logic [RECIP_W-1:0] RECIP_SPLIT [KIND_NUM] = '{
    RECIP_W'((64'd1 << RECIP_SHIFT) / (64'(KIND_TAU[0]) * 64'(SUBSTEP_COUNT))),
    RECIP_W'((64'd1 << RECIP_SHIFT) / (64'(KIND_TAU[1]) * 64'(SUBSTEP_COUNT))),
    RECIP_W'((64'd1 << RECIP_SHIFT) / (64'(KIND_TAU[2]) * 64'(SUBSTEP_COUNT))),
    RECIP_W'((64'd1 << RECIP_SHIFT) / (64'(KIND_TAU[3]) * 64'(SUBSTEP_COUNT)))
  };

  state_t state_r, state_nxt;

  // config
  logic [KIND_W-1:0]     kind_r;
  logic signed [V_W-1:0] rest_r;
  logic signed [V_W-1:0] reset_pot_r;
  logic signed [V_W-1:0] peak_r;
  logic signed [V_W-1:0] bias_r;
  logic [DECAY_W-1:0]    decay_r;

  // neuron state
  logic signed [V_W-1:0]       voltage_r;
  logic signed [CUR_SUM_W-1:0] cur_sum_r;
  logic [DT_W-1:0]             refr_r;
  logic [ACT_W-1:0]            act_r;

  // work registers
  logic [DT_W-1:0]          dt_r;
  logic signed [VW_W-1:0]   tgt_r;
  logic signed [VW_W-1:0]   vw_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [X_W-1:0]           a_r;
  logic [X_W-1:0]           q_r;
  logic                     neg_r;
  logic [DEN_W-1:0]         den_r;
  logic [RECIP_W-1:0]       recip_r;
  logic [SUB_W-1:0]         sub_left_r;
  logic                     euler_r;
  logic                     fired_r;

  logic                  out_valid_r;
  logic                  out_spiked_r;
  logic signed [V_W-1:0] out_voltage_r;
  logic [ACT_W-1:0]      out_act_r;
  logic                  out_refr_r;

  // control
  logic                      in_ready;
  logic                      in_acc;
  logic                      out_load;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  // datapath terms
  logic signed [CUR_SUM_W:0]   cs_sum;
  logic signed [CUR_SUM_W-1:0] cs_sat;
  logic [DT_W-1:0]             refr_dec;
  logic                        split;
  logic signed [VW_W-1:0]      tgt_nxt;
  logic signed [VW_W-1:0]      drive;
  logic signed [X_W-1:0]       x_val;
  logic signed [X_W:0]         x_ext;
  logic [X_W:0]                abs_sum;
  logic [X_W-1:0]              q_est;
  logic [X_W:0]                rem;
  logic                        bump;
  logic signed [VW_W-1:0]      q_s;
  logic                        spike_hit;
  logic [ACT_W:0]              act_sum;
  logic [ACT_W-1:0]            act_boost;
  logic signed [VW_W-1:0]      v_floor_c;
  logic signed [V_W-1:0]       v_clamp;

  assign in_acc = in_item.valid && in_ready;
  assign in_item.ready = in_ready;
  assign cfg_wr.ready = 1'b1;

  assign out_item.valid            = out_valid_r;
  assign out_item.spiked           = out_spiked_r;
  assign out_item.membrane_voltage = out_voltage_r;
  assign out_item.activity_level   = out_act_r;
  assign out_item.in_refractory    = out_refr_r;

  assign mul_p = mul_a * mul_b;

  assign cs_sum   = (CUR_SUM_W+1)'(cur_sum_r) + (CUR_SUM_W+1)'(in_item.current_in);
  assign cs_sat   = (cs_sum > (CUR_SUM_W+1)'(CUR_MAX)) ? CUR_MAX :
                    (cs_sum < (CUR_SUM_W+1)'(CUR_MIN)) ? CUR_MIN : cs_sum[CUR_SUM_W-1:0];
  assign refr_dec = (refr_r > in_item.time_step) ? (refr_r - in_item.time_step) : '0;
  assign split    = in_item.time_step > DT_SPLIT;
  assign tgt_nxt  = VW_W'(cur_sum_r) + VW_W'(bias_r) + VW_W'(rest_r);

  assign drive   = tgt_r - vw_r;
  // floor(p / 256) by arithmetic shift
  assign x_val   = $signed(prod_r[X_W+7:8]);
  assign x_ext   = (X_W+1)'(x_val);
  // negative: -x + den - 1 so that the quotient rounds toward minus infinity
  assign abs_sum = x_val[X_W-1] ? (~x_ext + (X_W+1)'(den_r)) : x_ext;
  assign q_est   = prod_r[RECIP_SHIFT +: X_W];
  assign rem     = (X_W+1)'(a_r) - (X_W+1)'(prod_r[X_W-1:0]);
  assign bump    = rem >= (X_W+1)'(den_r);
  assign q_s     = $signed(VW_W'(q_r));

  assign spike_hit = vw_r >= VW_W'(KIND_THRESH[kind_r]);
  assign act_sum   = (ACT_W+1)'(act_r) + (ACT_W+1)'(SPIKE_BOOST);
  assign act_boost = (act_sum > (ACT_W+1)'(ACT_ONE)) ? ACT_ONE : act_sum[ACT_W-1:0];
  assign v_floor_c = (vw_r < VW_W'(V_FLOOR)) ? VW_W'(V_FLOOR) : vw_r;
  assign v_clamp   = (v_floor_c > VW_W'(peak_r)) ? peak_r : v_floor_c[V_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_item.opcode))
            OP_STEP: state_nxt = (refr_r != '0) ? ST_DECAY : ST_MULDT;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MULDT:    state_nxt = ST_ABS;
      ST_ABS:      state_nxt = ST_RECIP;
      ST_RECIP:    state_nxt = ST_REM;
      ST_REM:      state_nxt = ST_CORR;
      ST_CORR:     state_nxt = ST_UPD;
      ST_UPD:      state_nxt = (sub_left_r == SUB_W'(1)) ? ST_FIRE : ST_MULDT;
      ST_FIRE:     state_nxt = spike_hit ? ST_CLAMP : ST_DECAY;
      ST_DECAY:    state_nxt = ST_DECAY_WB;
      ST_DECAY_WB: state_nxt = euler_r ? ST_CLAMP : ST_DONE;
      ST_CLAMP:    state_nxt = ST_DONE;
      ST_DONE:     state_nxt = out_load ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_MULDT: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(drive);
        mul_b  = $signed(MUL_B_W'(dt_r));
      end
      ST_RECIP: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_A_W'(a_r));
        mul_b  = $signed(MUL_B_W'(recip_r));
      end
      ST_REM: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_A_W'(q_est));
        mul_b  = $signed(MUL_B_W'(den_r));
      end
      ST_DECAY: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_A_W'(act_r));
        mul_b  = $signed(MUL_B_W'(decay_r));
      end
      ST_DONE: out_load = !out_valid_r || out_item.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= '0;
      rest_r      <= REST_RST;
      reset_pot_r <= RESET_POT_RST;
      peak_r      <= PEAK_RST;
      bias_r      <= BIAS_RST;
      decay_r     <= DECAY_RST;
      voltage_r   <= REST_RST;
      cur_sum_r   <= '0;
      refr_r      <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr.valid) begin
        case (cfg_reg_t'(cfg_wr.index))
          REG_KIND:      kind_r      <= cfg_wr.data[KIND_W-1:0];
          REG_REST:      rest_r      <= $signed(cfg_wr.data);
          REG_RESET_POT: reset_pot_r <= $signed(cfg_wr.data);
          REG_PEAK:      peak_r      <= $signed(cfg_wr.data);
          REG_BIAS:      bias_r      <= $signed(cfg_wr.data);
          REG_DECAY:     decay_r     <= cfg_wr.data;
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (op_t'(in_item.opcode))
              OP_INJECT: cur_sum_r <= cs_sat;
              OP_STEP: begin
                cur_sum_r <= '0;
                if (refr_r != '0) begin
                  refr_r <= refr_dec;
                end
              end
              OP_CLEAR: begin
                voltage_r <= rest_r;
                cur_sum_r <= '0;
                refr_r    <= '0;
                act_r     <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_FIRE: begin
          if (spike_hit) begin
            refr_r <= KIND_REFR[kind_r];
            act_r  <= act_boost;
          end
        end
        ST_DECAY_WB: act_r <= prod_r[16 +: ACT_W];
        ST_CLAMP:    voltage_r <= v_clamp;
        default: ;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_p;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          dt_r       <= in_item.time_step;
          fired_r    <= 1'b0;
          euler_r    <= (op_t'(in_item.opcode) == OP_STEP) && (refr_r == '0);
          tgt_r      <= tgt_nxt;
          vw_r       <= VW_W'(voltage_r);
          den_r      <= split ? DEN_SPLIT[kind_r] : DEN_W'(KIND_TAU[kind_r]);
          recip_r    <= split ? RECIP_SPLIT[kind_r] : RECIP_ONE[kind_r];
          sub_left_r <= split ? SUB_W'(SUBSTEP_COUNT) : SUB_W'(1);
        end
      end
      ST_ABS: begin
        a_r   <= abs_sum[X_W-1:0];
        neg_r <= x_val[X_W-1];
      end
      ST_REM:  q_r <= q_est;
      ST_CORR: q_r <= q_r + X_W'(bump);
      ST_UPD: begin
        vw_r       <= neg_r ? (vw_r - q_s) : (vw_r + q_s);
        sub_left_r <= sub_left_r - SUB_W'(1);
      end
      ST_FIRE: begin
        if (spike_hit) begin
          fired_r <= 1'b1;
          vw_r    <= VW_W'(reset_pot_r);
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_spiked_r  <= fired_r;
      out_voltage_r <= voltage_r;
      out_act_r     <= act_r;
      out_refr_r    <= refr_r != '0;
    end
  end

endmodule

`default_nettype wire

[design/lif_checker.sv]
`default_nettype none

module lif_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_spiked,
  input logic signed [lif_pkg::V_W-1:0] out_membrane_voltage,
  input logic [lif_pkg::ACT_W-1:0]      out_activity_level,
  input logic                           out_in_refractory
);
  import lif_pkg::*;

  // items accepted and not yet delivered
  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_spiked) &&
      $stable(out_membrane_voltage) && $stable(out_activity_level) &&
      $stable(out_in_refractory))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an item");

  a_spike_refr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_spiked |-> out_in_refractory)
    else $error("spike without refractory");

  a_act_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_activity_level <= ACT_ONE)
    else $error("activity above one");

endmodule

bind lif_neuron_update lif_checker u_lif_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_item.valid),
  .in_ready             (in_item.ready),
  .out_valid            (out_item.valid),
  .out_ready            (out_item.ready),
  .out_spiked           (out_item.spiked),
  .out_membrane_voltage (out_item.membrane_voltage),
  .out_activity_level   (out_item.activity_level),
  .out_in_refractory    (out_item.in_refractory)
);

`default_nettype wire

[dv/lif_update_checker.sv]
module lif_update_checker #(
  parameter int SUBSTEPS = 4
) (
  input  logic clk,
  input  logic rst_n,
  lif_cfg_if   cfg,
  lif_in_if    item_in,
  lif_out_if   item_out,
  output int   mismatch_count,
  output int   open_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import lif_pkg::*;

  typedef struct packed {
    logic                  spiked;
    logic signed [V_W-1:0] mv;
    logic [ACT_W-1:0]      act;
    logic                  refr;
  } neuron_out_t;

  localparam int     TAU_MS    [4] = '{10, 8, 12, 15};
  localparam longint THRESH_MV [4] = '{-14080, -14080, -14336, -13824};
  localparam int     REFR_LEN  [4] = '{384, 256, 512, 768};
  localparam longint ACC_MAX  = 524287;
  localparam longint ACC_MIN  = -524288;
  localparam longint FLOOR_MV = -20480;
  localparam int     SPLIT_DT = 384;
  localparam longint BOOST    = 26214;
  localparam longint ACT_FULL = 65536;

  logic [KIND_W-1:0]     kind_sel;
  logic signed [V_W-1:0] rest_mv, reset_mv, peak_mv, bias_cur;
  logic [DECAY_W-1:0]    decay_mul;

  logic signed [V_W-1:0]       v_mem;
  logic signed [CUR_SUM_W-1:0] i_acc;
  logic [DT_W-1:0]             refr_left;
  logic [ACT_W-1:0]            act;

  neuron_out_t predicted_outs[$];
  neuron_out_t seen_out, due_out;
  int          result_idx;

  initial mismatch_count = 0;

  function automatic longint floor_div(longint p, longint d);
    if (p >= 0) return p / d;
    return -((-p + d - 1) / d);
  endfunction

  function automatic logic [ACT_W-1:0] decayed(logic [ACT_W-1:0] a);
    return ACT_W'((longint'(a) * longint'(decay_mul)) >> 16);
  endfunction

  function automatic void clear_neuron();
    v_mem     = rest_mv;
    i_acc     = '0;
    refr_left = '0;
    act       = '0;
  endfunction

  function automatic neuron_out_t advance_neuron(logic [OPCODE_W-1:0] op,
                                                 logic signed [CUR_IN_W-1:0] cur,
                                                 logic [DT_W-1:0] dt);
    neuron_out_t r;
    longint      sum, v, den, drive, boosted;
    int          substeps;
    r.spiked = 1'b0;
    case (op)
      OP_INJECT: begin
        sum = longint'(i_acc) + longint'(cur);
        if (sum > ACC_MAX) sum = ACC_MAX;
        if (sum < ACC_MIN) sum = ACC_MIN;
        i_acc = CUR_SUM_W'(sum);
      end
      OP_STEP: begin
        if (refr_left != 0) begin
          refr_left = (refr_left > dt) ? refr_left - dt : '0;
          i_acc = '0;
          act = decayed(act);
        end else begin
          substeps = (int'(dt) > SPLIT_DT) ? SUBSTEPS : 1;
          den = longint'(TAU_MS[kind_sel]) * substeps * 256;
          v = longint'(v_mem);
          for (int s = 0; s < substeps; s++) begin
            drive = longint'(i_acc) + longint'(bias_cur) - (v - longint'(rest_mv));
            v = v + floor_div(drive * longint'(dt), den);
          end
          if (v >= THRESH_MV[kind_sel]) begin
            r.spiked = 1'b1;
            v = longint'(reset_mv);
            refr_left = DT_W'(REFR_LEN[kind_sel]);
            boosted = longint'(act) + BOOST;
            act = ACT_W'((boosted > ACT_FULL) ? ACT_FULL : boosted);
          end else begin
            act = decayed(act);
          end
          if (v < FLOOR_MV) v = FLOOR_MV;
          if (v > longint'(peak_mv)) v = longint'(peak_mv);
          v_mem = V_W'(v);
          i_acc = '0;
        end
      end
      OP_CLEAR: clear_neuron();
      default: ;
    endcase
    r.mv   = v_mem;
    r.act  = act;
    r.refr = (refr_left != 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("%0t ns result %0d: %s expected %0d, got %0d", $time, result_idx, what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      kind_sel  = '0;
      rest_mv   = REST_RST;
      reset_mv  = RESET_POT_RST;
      peak_mv   = PEAK_RST;
      bias_cur  = BIAS_RST;
      decay_mul = DECAY_RST;
      clear_neuron();
      predicted_outs.delete();
      result_idx = 0;
    end else begin
      if (item_out.valid && item_out.ready) begin
        seen_out.spiked = item_out.spiked;
        seen_out.mv     = item_out.membrane_voltage;
        seen_out.act    = item_out.activity_level;
        seen_out.refr   = item_out.in_refractory;
        if (predicted_outs.size() == 0) begin
          report_mismatch("item with nothing predicted, voltage", 0, seen_out.mv);
        end else begin
          due_out = predicted_outs.pop_front();
          if (seen_out.spiked !== due_out.spiked)
            report_mismatch("spiked", due_out.spiked, seen_out.spiked);
          if (seen_out.mv !== due_out.mv)
            report_mismatch("membrane_voltage", due_out.mv, seen_out.mv);
          if (seen_out.act !== due_out.act)
            report_mismatch("activity_level", due_out.act, seen_out.act);
          if (seen_out.refr !== due_out.refr)
            report_mismatch("in_refractory", due_out.refr, seen_out.refr);
        end
        result_idx++;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_KIND:      kind_sel  = KIND_W'(cfg.data);
          REG_REST:      rest_mv   = cfg.data;
          REG_RESET_POT: reset_mv  = cfg.data;
          REG_PEAK:      peak_mv   = cfg.data;
          REG_BIAS:      bias_cur  = cfg.data;
          REG_DECAY:     decay_mul = cfg.data;
          default: ;
        endcase
      end
      if (item_in.valid && item_in.ready)
        predicted_outs.push_back(advance_neuron(item_in.opcode, item_in.current_in,
                                                item_in.time_step));
    end
    open_results = predicted_outs.size();
  end

endmodule

[dv/lif_neuron_update_test.sv]
module lif_neuron_update_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lif_pkg::*;

  localparam int SUBSTEPS     = 4;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 190;
  localparam int IDLE_PCT  [4] = '{0, 78, 0, 7};
  localparam int STALL_PCT [4] = '{0, 0, 78, 7};
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  int   fails, pending, cycles;
  int   idle_pct, stall_pct;
  int   hold_ticket, hold_seen, hold_left;

  lif_cfg_if cfg_ch();
  lif_in_if  in_ch();
  lif_out_if out_ch();

  lif_neuron_update #(.SUBSTEP_COUNT(SUBSTEPS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_ch),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  lif_update_checker #(.SUBSTEPS(SUBSTEPS)) chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_ch),
    .item_in        (in_ch),
    .item_out       (out_ch),
    .mismatch_count (fails),
    .open_results   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen    <= hold_ticket;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic offer_item(logic [OPCODE_W-1:0] op, logic [CUR_IN_W-1:0] cur,
                            logic [DT_W-1:0] dt);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.current_in <= cur;
    in_ch.time_step  <= dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_setting(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic apply_settings(logic [KIND_W-1:0] kind, logic [15:0] rest, logic [15:0] rpot,
                                logic [15:0] peak, logic [15:0] bias, logic [15:0] decay);
    drain();
    write_setting(REG_KIND, CFG_DATA_W'(kind));
    write_setting(REG_REST, rest);
    write_setting(REG_RESET_POT, rpot);
    write_setting(REG_PEAK, peak);
    write_setting(REG_BIAS, bias);
    write_setting(REG_DECAY, decay);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [CUR_IN_W-1:0] pick_current();
    if ($urandom_range(7) == 0) return CUR_IN_W'($urandom);
    return CUR_IN_W'($urandom_range(9000)) - 16'd1500;
  endfunction

  function automatic logic [DT_W-1:0] pick_dt();
    if ($urandom_range(7) != 0) return DT_W'($urandom_range(1023));
    case ($urandom_range(3))
      0: return 10'd0;
      1: return 10'd384;
      2: return 10'd385;
      default: return 10'd1023;
    endcase
  endfunction

  // mostly inject bursts closed by a step, with clears, unused codes and bare steps mixed in
  task automatic drive_ticks(int count);
    int done, pick, burst;
    logic [CUR_IN_W-1:0] sat;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        offer_item(OP_CLEAR, CUR_IN_W'($urandom), DT_W'($urandom));
        done++;
      end else if (pick < 6) begin
        offer_item(OP_UNUSED, CUR_IN_W'($urandom), DT_W'($urandom));
        done++;
      end else if (pick < 9) begin
        burst = $urandom_range(20, 16);
        sat = $urandom_range(1) ? 16'h7fff : 16'h8000;
        repeat (burst) offer_item(OP_INJECT, sat, DT_W'($urandom));
        offer_item(OP_STEP, CUR_IN_W'($urandom), pick_dt());
        done += burst + 1;
      end else if (pick < 15) begin
        offer_item(OP_STEP, CUR_IN_W'($urandom), pick_dt());
        done++;
      end else begin
        burst = $urandom_range(3);
        repeat (burst) offer_item(OP_INJECT, pick_current(), DT_W'($urandom));
        offer_item(OP_STEP, CUR_IN_W'($urandom), pick_dt());
        done += burst + 1;
      end
    end
  endtask

  initial begin
    logic [15:0] rest_v;
    int mode;
    rst_n            = 1'b0;
    cycles           = 0;
    idle_pct         = 0;
    stall_pct        = 0;
    hold_ticket      = 0;
    hold_seen        = 0;
    hold_left        = 0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_INJECT;
    in_ch.current_in = '0;
    in_ch.time_step  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_KIND;
    cfg_ch.data      = '0;
    out_ch.ready     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    stall_pct <= 0;
    offer_item(OP_CLEAR, 16'h7fff, 10'h3ff);
    offer_item(OP_UNUSED, 16'h8000, 10'd0);
    offer_item(OP_STEP, 16'h0000, 10'd0);
    offer_item(OP_STEP, 16'hffff, 10'd384);
    offer_item(OP_STEP, 16'h5555, 10'd385);
    repeat (3) offer_item(OP_INJECT, 16'h7fff, 10'd0);
    offer_item(OP_STEP, 16'h0000, 10'd1023);
    offer_item(OP_STEP, 16'h0000, 10'd100);
    offer_item(OP_INJECT, 16'd1000, 10'h2aa);
    offer_item(OP_STEP, 16'h0000, 10'd1023);
    offer_item(OP_STEP, 16'h0000, 10'd0);
    repeat (2) offer_item(OP_INJECT, 16'h8000, 10'd5);
    offer_item(OP_STEP, 16'haaaa, 10'd1023);
    repeat (4) offer_item(OP_INJECT, 16'h7fff, 10'd0);
    offer_item(OP_STEP, 16'h0000, 10'd200);
    offer_item(OP_INJECT, 16'h7fff, 10'd1);
    offer_item(OP_CLEAR, 16'h0000, 10'd0);
    offer_item(OP_STEP, 16'h0000, 10'd1023);

    for (int phase = 0; phase < PHASES; phase++) begin
      mode = phase % 4;
      case (phase)
        0: apply_settings(2'd0, 16'hbf00, 16'hba00, 16'h1e00, 16'h0000, 16'd62259);
        1: apply_settings(2'd3, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
        2: apply_settings(2'd1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
        default: begin
          rest_v = 16'($urandom_range(3584)) - 16'd18432;
          apply_settings(KIND_W'(phase % 4), rest_v, rest_v - 16'($urandom_range(2560)),
                         $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(10240)),
                         16'($urandom_range(3072)) - 16'd512, 16'($urandom));
        end
      endcase
      idle_pct  = IDLE_PCT[mode];
      stall_pct <= STALL_PCT[mode];
      if (phase == 0) hold_ticket <= hold_ticket + 1;
      drive_ticks(PHASE_ITEMS / 2);
      if (phase == 3) drain();
      drive_ticks(PHASE_ITEMS / 2);
    end

    drain();
    repeat (40) @(posedge clk);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
design/lif_pkg.sv
design/lif_cfg_if.sv
design/lif_in_if.sv
design/lif_out_if.sv
design/lif_neuron_update.sv
design/lif_checker.sv
dv/lif_update_checker.sv
dv/lif_neuron_update_test.sv
